// ===== design/frame_from_point_normal_macros.svh =====
// ----------------------------------------------------------------------------
// Frame from point and normal: assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_FROM_POINT_NORMAL_MACROS_SVH
`define FRAME_FROM_POINT_NORMAL_MACROS_SVH

// same-cycle implication
`define FFPN_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFPN_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ffpn_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame from point and normal: package
// Beat types and fixed-point constants shared by the block.
// ----------------------------------------------------------------------------
package ffpn_pkg;

   // normal and axes are signed Q1.14
   localparam int NORM_FRAC_BITS = 14;
   localparam int NORM_ONE       = 1 << NORM_FRAC_BITS;
   localparam int NORM_HALF      = 1 << (NORM_FRAC_BITS - 1);

   // threshold register
   localparam int THR_W = 15;
   localparam logic [THR_W-1:0] THR_RESET =
      THR_W'(((9 << NORM_FRAC_BITS) + 5) / 10);

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] axis_x_x;
      logic signed [15:0] axis_x_y;
      logic signed [15:0] axis_x_z;
      logic signed [15:0] axis_y_x;
      logic signed [15:0] axis_y_y;
      logic signed [15:0] axis_y_z;
      logic signed [15:0] axis_z_x;
      logic signed [15:0] axis_z_y;
      logic signed [15:0] axis_z_z;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
   } rsp_type;

endpackage

// ===== design/frame_from_point_normal.sv =====
// Throughput: one beat per cycle while rsp_stall is low. The pipeline holds the 17-step square root
// and the 15-step divider, each one bit per pipeline stage.
// A stalled rsp holds the output stage; empty stages upstream still fill.
// Reset (synchronous) clears all stage valids and loads the threshold register thr_ff = 14746.
// ----------------------------------------------------------------------------
// Frame from point and normal
// Builds an orthonormal frame (x, y, z = normal) with the point as origin.
// ----------------------------------------------------------------------------
`include "frame_from_point_normal_macros.svh"

module frame_from_point_normal (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ffpn_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ffpn_pkg::rsp_type           rsp_data,
   input  logic                        csr_write_en,
   input  logic [ffpn_pkg::THR_W-1:0]  csr_write_data
);

   // stage map
   localparam int SQ_STEPS = 17;
   localparam int DV_STEPS = 15;
   localparam int ST_PROD  = 1;
   localparam int ST_PROJ  = 2;
   localparam int ST_SQ    = 3;
   localparam int ST_SUM   = 4;
   localparam int ST_DPREP = ST_SUM + SQ_STEPS + 1;
   localparam int ST_NORM  = ST_DPREP + DV_STEPS + 1;
   localparam int ST_XMUL  = ST_NORM + 1;
   localparam int ST_OUT   = ST_XMUL + 1;
   localparam int NST      = ST_OUT + 1;
   localparam int ONE      = ffpn_pkg::NORM_ONE;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               sel;   // 1: project global x
   } carry_type;

   typedef struct packed {
      logic [33:0]      v;
      logic [17:0]      rem;
      logic [16:0]      root;
      logic [2:0][17:0] p;
   } sqrt_type;

   typedef struct packed {
      logic [16:0]      len;
      logic             lenz;
      logic [2:0]       neg;
      logic [2:0][14:0] lo;
      logic [2:0][16:0] rem;
      logic [2:0][14:0] quo;
   } div_type;

   // rounding divide by ONE, half away from zero
   function automatic logic signed [17:0] rdiv_one(input logic signed [31:0] x);
      logic [31:0] mag;
      logic [17:0] q;
      mag = x[31] ? 32'(-x) : 32'(x);
      q   = 18'((mag + 32'(ffpn_pkg::NORM_HALF)) >> ffpn_pkg::NORM_FRAC_BITS);
      return x[31] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [17:0] x);
      logic signed [15:0] r;
      if (x > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (x < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = 16'(x);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // config register
   logic [ffpn_pkg::THR_W-1:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ffpn_pkg::THR_RESET;
      end else if (csr_write_en) begin
         thr_ff <= csr_write_data;
      end
   end

   // ---------------------------------------------------------------
   // stage valids and load enables (bubbles collapse under stall)
   logic [NST-1:0] vld_ff;
   logic [NST:0]   load;

   always_comb begin
      load[NST] = !rsp_stall;
      for (int s = NST - 1; s >= 0; s--) begin
         load[s] = !vld_ff[s] || load[s+1];
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (load[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int s = 1; s < NST; s++) begin
            if (load[s]) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // input stage and pass-through carry
   carry_type      car_ff [NST];
   carry_type      car_in;
   logic signed [16:0] nx_ext;
   logic [16:0]    absx;

   always_comb begin
      nx_ext      = 17'(req_data.normal_x);
      absx        = nx_ext[16] ? 17'(-nx_ext) : 17'(nx_ext);
      car_in.px   = req_data.point_x;
      car_in.py   = req_data.point_y;
      car_in.pz   = req_data.point_z;
      car_in.nx   = req_data.normal_x;
      car_in.ny   = req_data.normal_y;
      car_in.nz   = req_data.normal_z;
      car_in.sel  = absx < {2'b00, thr_ff};
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         car_ff[0] <= car_in;
      end
      for (int s = 1; s < NST; s++) begin
         if (load[s]) begin
            car_ff[s] <= car_ff[s-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // products n_sel * n_k
   logic signed [31:0] prod_ff [3];
   logic signed [15:0] pm;

   assign pm = car_ff[ST_PROD-1].sel ? car_ff[ST_PROD-1].nx : car_ff[ST_PROD-1].ny;

   always_ff @(posedge clock) begin
      if (load[ST_PROD]) begin
         prod_ff[0] <= pm * car_ff[ST_PROD-1].nx;
         prod_ff[1] <= pm * car_ff[ST_PROD-1].ny;
         prod_ff[2] <= pm * car_ff[ST_PROD-1].nz;
      end
   end

   // ---------------------------------------------------------------
   // projection p = e - n_sel * n
   logic signed [17:0] proj_ff [3];
   logic signed [17:0] proj_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         proj_in[k] = -rdiv_one(prod_ff[k]);
      end
      if (car_ff[ST_PROJ-1].sel) begin
         proj_in[0] = proj_in[0] + 18'sd16384;
      end else begin
         proj_in[1] = proj_in[1] + 18'sd16384;
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_PROJ]) begin
         proj_ff <= proj_in;
      end
   end

   // ---------------------------------------------------------------
   // squares
   logic [32:0]        sq_ff [3];
   logic signed [17:0] psq_ff [3];
   logic [16:0]        pmag [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pmag[k] = proj_ff[k][17] ? 17'(-proj_ff[k]) : 17'(proj_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_SQ]) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k]  <= 33'(34'(pmag[k]) * 34'(pmag[k]));
            psq_ff[k] <= proj_ff[k];
         end
      end
   end

   // ---------------------------------------------------------------
   // sum of squares, then one root bit per stage
   sqrt_type sqs_ff [SQ_STEPS+1];
   sqrt_type sum_in;

   always_comb begin
      sum_in.v    = 34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]);
      sum_in.rem  = '0;
      sum_in.root = '0;
      for (int k = 0; k < 3; k++) begin
         sum_in.p[k] = psq_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_SUM]) begin
         sqs_ff[0] <= sum_in;
      end
   end

   for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_sqrt
      localparam int HI = 33 - 2 * (i - 1);
      sqrt_type    nxt;
      logic [19:0] rr;
      logic [19:0] tr;

      always_comb begin
         nxt = sqs_ff[i-1];
         rr  = {sqs_ff[i-1].rem, sqs_ff[i-1].v[HI -: 2]};
         tr  = {1'b0, sqs_ff[i-1].root, 2'b01};
         if (rr >= tr) begin
            nxt.rem  = 18'(rr - tr);
            nxt.root = {sqs_ff[i-1].root[15:0], 1'b1};
         end else begin
            nxt.rem  = 18'(rr);
            nxt.root = {sqs_ff[i-1].root[15:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (load[ST_SUM+i]) begin
            sqs_ff[i] <= nxt;
         end
      end
   end

   // ---------------------------------------------------------------
   // divider setup: a = |p| * ONE + len / 2
   div_type  dvs_ff [DV_STEPS+1];
   div_type  dprep_in;
   logic [30:0] dnum [3];
   logic [16:0] dmag [3];

   always_comb begin
      dprep_in.len  = sqs_ff[SQ_STEPS].root;
      dprep_in.lenz = sqs_ff[SQ_STEPS].root == '0;
      for (int k = 0; k < 3; k++) begin
         dmag[k] = sqs_ff[SQ_STEPS].p[k][17] ? 17'(-$signed(sqs_ff[SQ_STEPS].p[k]))
                                            : sqs_ff[SQ_STEPS].p[k][16:0];
         dnum[k] = {dmag[k], 14'b0} + 31'(sqs_ff[SQ_STEPS].root >> 1);
         dprep_in.neg[k] = sqs_ff[SQ_STEPS].p[k][17];
         dprep_in.rem[k] = {1'b0, dnum[k][30:15]};
         dprep_in.lo[k]  = dnum[k][14:0];
         dprep_in.quo[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_DPREP]) begin
         dvs_ff[0] <= dprep_in;
      end
   end

   // one quotient bit per stage, three lanes
   for (genvar j = 1; j <= DV_STEPS; j++) begin : g_div
      div_type     nxt;
      logic [17:0] rr [3];

      always_comb begin
         nxt = dvs_ff[j-1];
         for (int k = 0; k < 3; k++) begin
            rr[k]     = {dvs_ff[j-1].rem[k], dvs_ff[j-1].lo[k][14]};
            nxt.lo[k] = {dvs_ff[j-1].lo[k][13:0], 1'b0};
            if (rr[k] >= {1'b0, dvs_ff[j-1].len}) begin
               nxt.rem[k] = 17'(rr[k] - {1'b0, dvs_ff[j-1].len});
               nxt.quo[k] = {dvs_ff[j-1].quo[k][13:0], 1'b1};
            end else begin
               nxt.rem[k] = 17'(rr[k]);
               nxt.quo[k] = {dvs_ff[j-1].quo[k][13:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (load[ST_DPREP+j]) begin
            dvs_ff[j] <= nxt;
         end
      end
   end

   // ---------------------------------------------------------------
   // normalized projected axis u (zero when the projection is zero)
   logic signed [15:0] u_ff [3];
   logic signed [15:0] u_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dvs_ff[DV_STEPS].lenz) begin
            u_in[k] = '0;
         end else if (dvs_ff[DV_STEPS].neg[k]) begin
            u_in[k] = -$signed({1'b0, dvs_ff[DV_STEPS].quo[k]});
         end else begin
            u_in[k] = $signed({1'b0, dvs_ff[DV_STEPS].quo[k]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[ST_NORM]) begin
         u_ff <= u_in;
      end
   end

   // ---------------------------------------------------------------
   // cross products n x u
   logic signed [31:0] xa_ff [3];
   logic signed [31:0] xb_ff [3];
   logic signed [15:0] ux_ff [3];
   logic signed [15:0] cn0;
   logic signed [15:0] cn1;
   logic signed [15:0] cn2;

   assign cn0 = car_ff[ST_XMUL-1].nx;
   assign cn1 = car_ff[ST_XMUL-1].ny;
   assign cn2 = car_ff[ST_XMUL-1].nz;

   always_ff @(posedge clock) begin
      if (load[ST_XMUL]) begin
         xa_ff[0] <= cn1 * u_ff[2];
         xb_ff[0] <= cn2 * u_ff[1];
         xa_ff[1] <= cn2 * u_ff[0];
         xb_ff[1] <= cn0 * u_ff[2];
         xa_ff[2] <= cn0 * u_ff[1];
         xb_ff[2] <= cn1 * u_ff[0];
         ux_ff    <= u_ff;
      end
   end

   // ---------------------------------------------------------------
   // output stage: round, saturate, assign axes
   ffpn_pkg::rsp_type  rsp_ff;
   ffpn_pkg::rsp_type  rsp_in;
   logic signed [31:0] xd [3];
   logic signed [15:0] xc [3];
   carry_type          oc;

   always_comb begin
      oc = car_ff[ST_OUT-1];
      for (int k = 0; k < 3; k++) begin
         xd[k] = oc.sel ? (xa_ff[k] - xb_ff[k]) : (xb_ff[k] - xa_ff[k]);
         xc[k] = sat16(rdiv_one(xd[k]));
      end
      if (oc.sel) begin
         rsp_in.axis_x_x = ux_ff[0];
         rsp_in.axis_x_y = ux_ff[1];
         rsp_in.axis_x_z = ux_ff[2];
         rsp_in.axis_y_x = xc[0];
         rsp_in.axis_y_y = xc[1];
         rsp_in.axis_y_z = xc[2];
      end else begin
         rsp_in.axis_x_x = xc[0];
         rsp_in.axis_x_y = xc[1];
         rsp_in.axis_x_z = xc[2];
         rsp_in.axis_y_x = ux_ff[0];
         rsp_in.axis_y_y = ux_ff[1];
         rsp_in.axis_y_z = ux_ff[2];
      end
      rsp_in.axis_z_x = oc.nx;
      rsp_in.axis_z_y = oc.ny;
      rsp_in.axis_z_z = oc.nz;
      rsp_in.origin_x = oc.px;
      rsp_in.origin_y = oc.py;
      rsp_in.origin_z = oc.pz;
   end

   always_ff @(posedge clock) begin
      if (load[ST_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // ---------------------------------------------------------------
   // assertions
   logic        u_in_range;
   logic        root_exact;
   logic [17:0] root_lo;
   logic [17:0] root_hi;

   assign u_in_range = (u_ff[0] <= ONE) && (u_ff[0] >= -ONE)
                    && (u_ff[1] <= ONE) && (u_ff[1] >= -ONE)
                    && (u_ff[2] <= ONE) && (u_ff[2] >= -ONE);

   // root^2 <= v < (root + 1)^2
   assign root_lo    = {1'b0, sqs_ff[SQ_STEPS].root};
   assign root_hi    = root_lo + 18'd1;
   assign root_exact = (36'(root_lo) * 36'(root_lo) <= 36'(sqs_ff[SQ_STEPS].v))
                    && (36'(root_hi) * 36'(root_hi) > 36'(sqs_ff[SQ_STEPS].v));

   `FFPN_ASSERT_IMP(a_empty_out_accepts, !vld_ff[NST-1], !req_stall, "stall with empty output")
   `FFPN_ASSERT_IMP(a_unit_axis, vld_ff[ST_NORM], u_in_range, "normalized axis out of range")
   `FFPN_ASSERT_IMP(a_isqrt, vld_ff[ST_SUM+SQ_STEPS], root_exact, "square root mismatch")

endmodule
